FILE: rtl/crc8_packet_deframer_core_assert.svh
// Assertion helpers used by the deframer controller RTL.
`ifndef CRC8_PACKET_DEFRAMER_CORE_ASSERT_SVH
`define CRC8_PACKET_DEFRAMER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CPD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cpd: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define CPD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cpd: next-cycle check failed");

`endif

FILE: rtl/cpd_pkg.sv
`default_nettype none

package cpd_pkg;

   localparam int unsigned DATA_W            = 8;
   localparam int unsigned POS_W             = 5;
   localparam int unsigned PAYLOAD_BYTES_DEF = 19;

   localparam logic [DATA_W-1:0] HEADER_RESET = 8'hAA;
   localparam logic [DATA_W-1:0] CRC_POLY     = 8'h07;
   localparam logic [DATA_W-1:0] CRC_TOP      = 8'h80;
   localparam logic [DATA_W-1:0] CRC_INIT     = 8'h00;

   typedef enum logic [1:0] {
      ST_HUNT,
      ST_PAYLOAD,
      ST_CHECK,
      ST_EMIT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic frame_start;  // header seen: clear CRC and index
      logic store;        // write payload byte, fold CRC, bump index
      logic emit_start;   // CRC matched: rewind index for readout
      logic emit_read;    // read one stored byte into the output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic hdr_match;
      logic crc_match;
      logic idx_last;
      logic slot_free;
   } sts_type;

   // CRC-8, poly 0x07, MSB first
   function automatic logic [DATA_W-1:0] crc8_fold(input logic [DATA_W-1:0] crc,
                                                   input logic [DATA_W-1:0] b);
      logic [DATA_W-1:0] v;
      v = crc ^ b;
      for (int i = 0; i < DATA_W; i++) begin
         if ((v & CRC_TOP) != '0) begin
            v = (v << 1) ^ CRC_POLY;
         end else begin
            v = v << 1;
         end
      end
      return v;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/cpd_ctrl.sv
`default_nettype none

`include "crc8_packet_deframer_core_assert.svh"

module cpd_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  cpd_pkg::sts_type    sts,
   output cpd_pkg::cmd_type    cmd
);

   cpd_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cpd_pkg::ST_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         cpd_pkg::ST_HUNT: begin
            if (req_valid && sts.hdr_match) begin
               cmd.frame_start = 1'b1;
               state_in        = cpd_pkg::ST_PAYLOAD;
            end
         end
         cpd_pkg::ST_PAYLOAD: begin
            if (req_valid) begin
               cmd.store = 1'b1;
               if (sts.idx_last) begin
                  state_in = cpd_pkg::ST_CHECK;
               end
            end
         end
         cpd_pkg::ST_CHECK: begin
            if (req_valid) begin
               if (sts.crc_match) begin
                  cmd.emit_start = 1'b1;
                  state_in       = cpd_pkg::ST_EMIT;
               end else begin
                  state_in = cpd_pkg::ST_HUNT;
               end
            end
         end
         cpd_pkg::ST_EMIT: begin
            req_stall = 1'b1;
            if (sts.slot_free) begin
               cmd.emit_read = 1'b1;
               if (sts.idx_last) begin
                  state_in = cpd_pkg::ST_HUNT;
               end
            end
         end
         default: begin
            state_in = cpd_pkg::ST_HUNT;
         end
      endcase
   end

   `CPD_ASSERT_NOW(a_read_needs_slot, clock, reset, cmd.emit_read, sts.slot_free)
   `CPD_ASSERT_NOW(a_emit_on_match, clock, reset, cmd.emit_start, req_valid && sts.crc_match)
   `CPD_ASSERT_NEXT(a_burst_ends, clock, reset, cmd.emit_read && sts.idx_last,
                    state_ff == cpd_pkg::ST_HUNT)
   `CPD_ASSERT_NOW(a_no_store_in_burst, clock, reset, cmd.emit_read, !cmd.store)

endmodule

`default_nettype wire

FILE: rtl/cpd_dp.sv
`default_nettype none

module cpd_dp #(
   parameter int unsigned PAYLOAD_BYTES = cpd_pkg::PAYLOAD_BYTES_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          csr_valid,
   input  wire  [cpd_pkg::DATA_W-1:0]   csr_header_byte,
   input  wire  [cpd_pkg::DATA_W-1:0]   req_rx_byte,
   input  wire                          rsp_stall,
   output logic                         rsp_valid,
   output logic [cpd_pkg::DATA_W-1:0]   rsp_payload_byte,
   output logic [cpd_pkg::POS_W-1:0]    rsp_byte_position,
   output logic                         rsp_last_byte,
   input  cpd_pkg::cmd_type             cmd,
   output cpd_pkg::sts_type             sts
);

   localparam int unsigned IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PAYLOAD_BYTES - 1);

   logic [cpd_pkg::DATA_W-1:0] hdr_ff;
   logic [cpd_pkg::DATA_W-1:0] crc_ff;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic                       out_valid_ff;
   logic [cpd_pkg::DATA_W-1:0] rd_data_ff;
   logic [cpd_pkg::POS_W-1:0]  pos_ff;
   logic                       last_ff;
   logic [IDX_W+cpd_pkg::POS_W-1:0] idx_wide;

   logic [cpd_pkg::DATA_W-1:0] store_mem [PAYLOAD_BYTES];

   assign idx_wide = {{cpd_pkg::POS_W{1'b0}}, idx_ff};

   always_comb begin
      idx_in = idx_ff;
      if (cmd.frame_start || cmd.emit_start) begin
         idx_in = '0;
      end else if (cmd.store || cmd.emit_read) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff       <= cpd_pkg::HEADER_RESET;
         crc_ff       <= cpd_pkg::CRC_INIT;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            hdr_ff <= csr_header_byte;
         end
         if (cmd.frame_start) begin
            crc_ff <= cpd_pkg::CRC_INIT;
         end else if (cmd.store) begin
            crc_ff <= cpd_pkg::crc8_fold(crc_ff, req_rx_byte);
         end
         idx_ff <= idx_in;
         if (cmd.emit_read) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload store and readout register
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         store_mem[idx_ff] <= req_rx_byte;
      end
      if (cmd.emit_read) begin
         rd_data_ff <= store_mem[idx_ff];
         pos_ff     <= idx_wide[cpd_pkg::POS_W-1:0];
         last_ff    <= (idx_ff == IDX_LAST);
      end
   end

   assign sts.hdr_match = (req_rx_byte == hdr_ff);
   assign sts.crc_match = (req_rx_byte == crc_ff);
   assign sts.idx_last  = (idx_ff == IDX_LAST);
   assign sts.slot_free = !out_valid_ff || !rsp_stall;

   assign rsp_valid         = out_valid_ff;
   assign rsp_payload_byte  = rd_data_ff;
   assign rsp_byte_position = pos_ff;
   assign rsp_last_byte     = last_ff;

endmodule

`default_nettype wire

FILE: rtl/crc8_packet_deframer_core.sv
// After the CRC byte, the first payload request passes the state and output registers.
// Throughput: a frame takes PAYLOAD_BYTES+2 input requests; a good frame then
//   streams PAYLOAD_BYTES results, one per cycle without rsp stall, input held off.
// Sync active-high reset: hunting for a header, CRC zero, header register 0xAA.
// The payload store is not cleared; every entry is written before it is read.
`default_nettype none

module crc8_packet_deframer_core #(
   parameter int unsigned PAYLOAD_BYTES = cpd_pkg::PAYLOAD_BYTES_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   // header byte register write
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire  [cpd_pkg::DATA_W-1:0]   csr_header_byte,
   // received byte requests
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire  [cpd_pkg::DATA_W-1:0]   req_rx_byte,
   // checked payload requests
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [cpd_pkg::DATA_W-1:0]   rsp_payload_byte,
   output logic [cpd_pkg::POS_W-1:0]    rsp_byte_position,
   output logic                         rsp_last_byte
);

   cpd_pkg::cmd_type cmd;
   cpd_pkg::sts_type sts;

   // header register is always writable; a write during a frame applies
   // from the next header hunt
   assign csr_ready = 1'b1;

   // sequencer: hunt -> payload -> CRC check -> readout burst
   cpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // store, CRC, shared index counter and output register
   cpd_dp #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid & csr_ready),
      .csr_header_byte   (csr_header_byte),
      .req_rx_byte       (req_rx_byte),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_byte_position (rsp_byte_position),
      .rsp_last_byte     (rsp_last_byte),
      .cmd               (cmd),
      .sts               (sts)
   );

endmodule

`default_nettype wire

FILE: tb/sv/crc8_packet_deframer_core_tb.sv
`default_nettype none

// Deframer testbench: drives received-byte requests with random gaps,
// stalls the payload side at random, and checks every emitted payload
// request against a local frame tracker that mirrors the hunt / payload /
// CRC sequence of the block.
module crc8_packet_deframer_core_tb;

   localparam int unsigned FRAME_LEN   = cpd_pkg::PAYLOAD_BYTES_DEF;
   localparam int unsigned W           = cpd_pkg::DATA_W;
   localparam int unsigned PW          = cpd_pkg::POS_W;
   localparam int unsigned HANG_LIMIT  = 1000;  // cycles with no handshake at all
   localparam int unsigned QUIET_TIME  = 16;    // settle time once nothing is due
   localparam int unsigned MAX_REPORTS = 10;

   typedef logic [W-1:0] frame_body_type [FRAME_LEN];

   // One emitted payload request as the block should present it
   typedef struct packed {
      logic [W-1:0]  data;
      logic [PW-1:0] pos;
      logic          last;
   } payload_beat_type;

   // ---------------------------------------------------------------------
   // Clock, reset, DUT
   // ---------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   logic          csr_valid       = 1'b0;
   logic          csr_ready;
   logic [W-1:0]  csr_header_byte = '0;
   logic          req_valid       = 1'b0;
   logic          req_stall;
   logic [W-1:0]  req_rx_byte     = '0;
   logic          rsp_valid;
   logic          rsp_stall       = 1'b0;
   logic [W-1:0]  rsp_payload_byte;
   logic [PW-1:0] rsp_byte_position;
   logic          rsp_last_byte;

   crc8_packet_deframer_core u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_header_byte   (csr_header_byte),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_byte_position (rsp_byte_position),
      .rsp_last_byte     (rsp_last_byte)
   );

   // ---------------------------------------------------------------------
   // Frame tracker: local copy of header register, payload store, frame
   // position and running CRC. Fed with every accepted rx request.
   // ---------------------------------------------------------------------
   logic [W-1:0]  hdr_q    = cpd_pkg::HEADER_RESET;
   logic [W-1:0]  pay_mem [FRAME_LEN];
   int unsigned   fpos     = 0;          // 0 hunting, 1..N payload, N+1 CRC next
   logic [W-1:0]  crc_acc  = cpd_pkg::CRC_INIT;

   payload_beat_type beats_due[$];       // payload requests still to come out
   int unsigned   mismatches = 0;

   // Bitwise MSB-first CRC-8 step
   function automatic logic [W-1:0] crc8_next(input logic [W-1:0] acc,
                                              input logic [W-1:0] rx);
      logic [W-1:0] r;
      logic         fb;
      r = acc;
      for (int i = W - 1; i >= 0; i--) begin
         fb = r[W-1] ^ rx[i];
         r  = {r[W-2:0], 1'b0};
         if (fb) begin
            r = r ^ cpd_pkg::CRC_POLY;
         end
      end
      return r;
   endfunction

   task automatic track_rx(input logic [W-1:0] rx);
      payload_beat_type beat;
      if (fpos == 0) begin
         // Hunting: anything but the header is dropped
         if (rx == hdr_q) begin
            fpos    = 1;
            crc_acc = cpd_pkg::CRC_INIT;
         end
      end else if (fpos <= FRAME_LEN) begin
         // Header value here is plain payload, no resync
         pay_mem[fpos-1] = rx;
         crc_acc         = crc8_next(crc_acc, rx);
         fpos++;
      end else begin
         // CRC byte: good frame releases the whole store, bad frame nothing
         if (rx == crc_acc) begin
            for (int k = 0; k < FRAME_LEN; k++) begin
               beat.data = pay_mem[k];
               beat.pos  = PW'(k);
               beat.last = (k == FRAME_LEN - 1);
               beats_due.push_back(beat);
            end
         end
         fpos    = 0;
         crc_acc = cpd_pkg::CRC_INIT;
      end
   endtask

   // ---------------------------------------------------------------------
   // Idle / stall control
   // ---------------------------------------------------------------------
   bit          req_gaps_on = 1'b1;
   bit          rsp_gaps_on = 1'b1;
   int unsigned rsp_hold    = 0;

   // Gap per request: often zero so back-to-back runs happen too
   function automatic int unsigned draw_gap(input bit enabled);
      if (!enabled || $urandom_range(0, 3) == 0) begin
         return 0;
      end
      return $urandom_range(0, 14);
   endfunction

   // Stall is held for the drawn count after each accepted payload request
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold  = rsp_hold - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Payload request checker
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      payload_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (beats_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("unexpected payload request: byte %h pos %0d last %b",
                        rsp_payload_byte, rsp_byte_position, rsp_last_byte);
            end
         end else begin
            want = beats_due.pop_front();
            if (rsp_payload_byte !== want.data || rsp_byte_position !== want.pos ||
                rsp_last_byte !== want.last) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("payload mismatch: want byte %h pos %0d last %b, got byte %h pos %0d last %b",
                           want.data, want.pos, want.last,
                           rsp_payload_byte, rsp_byte_position, rsp_last_byte);
               end
            end
         end
         rsp_hold = draw_gap(rsp_gaps_on);
      end
   end

   // ---------------------------------------------------------------------
   // Hang watchdog: any handshake resets the count
   // ---------------------------------------------------------------------
   int unsigned hang_count = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         hang_count = 0;
      end else begin
         hang_count = hang_count + 1;
         if (hang_count >= HANG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------

   // One rx request: optional gap, then hold until taken
   task automatic push_byte(input logic [W-1:0] rx);
      int unsigned gap;
      gap = draw_gap(req_gaps_on);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      do @(posedge clock); while (req_stall);
      track_rx(rx);
   endtask

   // Stop sending, wait for every due payload request, then let a
   // failed frame's check finish inside the block
   task automatic drain_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (beats_due.size() != 0) @(posedge clock);
      repeat (QUIET_TIME) @(posedge clock);
   endtask

   task automatic write_header(input logic [W-1:0] value);
      drain_block();
      @(negedge clock);
      csr_valid       <= 1'b1;
      csr_header_byte <= value;
      do @(posedge clock); while (!csr_ready);
      hdr_q = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Header, payload, then the CRC byte (corrupted when crc_ok is clear)
   task automatic send_frame(input frame_body_type body, input bit crc_ok);
      logic [W-1:0] sum;
      sum = cpd_pkg::CRC_INIT;
      push_byte(hdr_q);
      for (int k = 0; k < FRAME_LEN; k++) begin
         sum = crc8_next(sum, body[k]);
         push_byte(body[k]);
      end
      push_byte(crc_ok ? sum : sum ^ W'($urandom_range(1, 255)));
   endtask

   // Filler that never looks like a header
   function automatic logic [W-1:0] noise_byte();
      logic [W-1:0] v;
      v = W'($urandom_range(0, 255));
      if (v == hdr_q) begin
         v = v ^ 8'h01;
      end
      return v;
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset header value, junk before the header, payload with extremes
   // and header copies inside it, correct CRC
   task automatic test_good_frame();
      frame_body_type body;
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(8'h55);
      for (int k = 0; k < FRAME_LEN; k++) begin
         body[k] = W'($urandom_range(0, 255));
      end
      body[0] = 8'h00;
      body[1] = 8'hFF;
      body[2] = hdr_q;
      body[3] = hdr_q;
      body[4] = 8'h80;
      body[5] = 8'h7F;
      body[FRAME_LEN-1] = 8'hFF;
      send_frame(body, 1'b1);
   endtask

   // Bad CRC on a frame full of header copies: nothing comes out and the
   // following all-zero frame (CRC 0x00) must parse cleanly
   task automatic test_crc_mismatch();
      frame_body_type body;
      for (int k = 0; k < FRAME_LEN; k++) begin
         body[k] = hdr_q;
      end
      send_frame(body, 1'b0);
      for (int k = 0; k < FRAME_LEN; k++) begin
         body[k] = 8'h00;
      end
      send_frame(body, 1'b1);
   endtask

   // Mostly well-formed frames with random content, some junk between
   // them and about one in five with a broken CRC
   task automatic test_random_frames(input int unsigned n_frames,
                                     input bit req_gaps, input bit rsp_gaps);
      frame_body_type body;
      int unsigned pick;
      req_gaps_on = req_gaps;
      rsp_gaps_on = rsp_gaps;
      repeat (n_frames) begin
         repeat ($urandom_range(0, 3)) push_byte(noise_byte());
         for (int k = 0; k < FRAME_LEN; k++) begin
            pick = $urandom_range(0, 9);
            unique case (pick)
               0: begin
                  body[k] = hdr_q;
               end
               1: begin
                  body[k] = 8'h00;
               end
               2: begin
                  body[k] = 8'hFF;
               end
               default: begin
                  body[k] = W'($urandom_range(0, 255));
               end
            endcase
         end
         send_frame(body, $urandom_range(0, 4) != 0);
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_good_frame();
      test_crc_mismatch();
      test_random_frames(3, 1'b1, 1'b1);

      write_header(8'h00);
      test_random_frames(3, 1'b0, 1'b0);

      write_header(8'hFF);
      test_random_frames(3, 1'b1, 1'b0);

      write_header(W'($urandom_range(0, 255)));
      test_random_frames(2, 1'b0, 1'b1);

      write_header(W'($urandom_range(0, 255)));
      test_random_frames(2, 1'b1, 1'b1);

      drain_block();

      if (mismatches == 0 && beats_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: crc8_packet_deframer_core.f
+incdir+rtl
rtl/cpd_pkg.sv
rtl/cpd_ctrl.sv
rtl/cpd_dp.sv
rtl/crc8_packet_deframer_core.sv
tb/sv/crc8_packet_deframer_core_tb.sv
